/* src/ipv4ft_pkg.sv */
package ipv4ft_pkg;

   localparam int unsigned OFFSET_WIDTH = 16;

   localparam logic [OFFSET_WIDTH-1:0] OFF_KIND_HI  = 16'd12;
   localparam logic [OFFSET_WIDTH-1:0] OFF_KIND_LO  = 16'd13;
   localparam logic [OFFSET_WIDTH-1:0] OFF_IHL      = 16'd14;
   localparam logic [OFFSET_WIDTH-1:0] OFF_PROTO    = 16'd23;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SRC_0    = 16'd26;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SRC_1    = 16'd27;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SRC_2    = 16'd28;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SRC_3    = 16'd29;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DST_0    = 16'd30;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DST_1    = 16'd31;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DST_2    = 16'd32;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DST_3    = 16'd33;
   localparam logic [OFFSET_WIDTH-1:0] ADDR_END     = 16'd34;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX   = 16'hFFFF;

   localparam logic [6:0]  ETH_HDR_BYTES = 7'd14;
   localparam logic [6:0]  PORT_BYTES    = 7'd4;
   localparam logic [15:0] IPV4_KIND     = 16'h0800;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] byte_offset;
      logic [15:0]             ether_kind;
      logic [3:0]              header_words;
      logic [7:0]              proto_seen;
      logic [31:0]             src_addr;
      logic [31:0]             dst_addr;
      logic [15:0]             src_port;
      logic [15:0]             dst_port;
   } frame_state_type;

   function automatic logic [6:0] port_start(input logic [3:0] words);
      return ETH_HDR_BYTES + {1'b0, words, 2'b00};
   endfunction

endpackage

/* src/ipv4_five_tuple_extractor_core.sv */
// Ethernet/IPv4 five-tuple extractor.
// req channel: one frame byte per transfer (req_frame_byte), with
// req_last_byte marking the final byte. Byte 0 is destination MAC byte 0.
// rsp channel: one transfer per IPv4 frame (EtherType 0x0800) carrying the
// addresses, protocol, ports (0 unless TCP/UDP, IHL >= 5), the frame length
// (saturating at 65535) and the short-frame / bad-header-length flags.
// Non-IPv4 frames produce no transfer.
// Throughput: one byte per cycle across frames while req_stall is low.
// The accepted last byte lands in the input register; from there
// it is parsed into the result register, which drives the rsp channel.
// Reset clears the frame state and both valid registers; no result pending.
// When rsp_stall holds a result, non-final bytes keep flowing; the next
// frame-ending byte that yields a result waits in the parse stage and
// req_stall rises until the held result is taken.
module ipv4_five_tuple_extractor_core
   import ipv4ft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_dest_address,
   output logic [7:0]  rsp_protocol_number,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_short_frame,
   output logic        rsp_bad_header_length
);

   logic            in_valid_ff;
   logic [7:0]      byte_ff;
   logic            last_ff;
   logic            advance;
   frame_state_type view;

   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff <= req_frame_byte;
         last_ff <= req_last_byte;
      end
   end

   ipv4ft_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .proc_valid (in_valid_ff),
      .advance    (advance),
      .byte_value (byte_ff),
      .last_flag  (last_ff),
      .view       (view)
   );

   ipv4ft_result u_result (
      .clock                 (clock),
      .reset                 (reset),
      .proc_valid            (in_valid_ff),
      .last_flag             (last_ff),
      .view                  (view),
      .advance               (advance),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_source_address    (rsp_source_address),
      .rsp_dest_address      (rsp_dest_address),
      .rsp_protocol_number   (rsp_protocol_number),
      .rsp_source_port       (rsp_source_port),
      .rsp_dest_port         (rsp_dest_port),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_short_frame       (rsp_short_frame),
      .rsp_bad_header_length (rsp_bad_header_length)
   );

endmodule

/* src/ipv4ft_capture.sv */
module ipv4ft_capture
   import ipv4ft_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            proc_valid,
   input  logic            advance,
   input  logic [7:0]      byte_value,
   input  logic            last_flag,
   output frame_state_type view
);

   frame_state_type state_ff;
   frame_state_type state_in;
   logic [OFFSET_WIDTH-1:0] off;
   logic [OFFSET_WIDTH-1:0] pstart;

   assign off = state_ff.byte_offset;

   always_comb begin
      view = state_ff;
      unique case (off)
         OFF_KIND_HI: view.ether_kind[15:8]  = byte_value;
         OFF_KIND_LO: view.ether_kind[7:0]   = byte_value;
         OFF_IHL:     view.header_words      = byte_value[3:0];
         OFF_PROTO:   view.proto_seen        = byte_value;
         OFF_SRC_0:   view.src_addr[31:24]   = byte_value;
         OFF_SRC_1:   view.src_addr[23:16]   = byte_value;
         OFF_SRC_2:   view.src_addr[15:8]    = byte_value;
         OFF_SRC_3:   view.src_addr[7:0]     = byte_value;
         OFF_DST_0:   view.dst_addr[31:24]   = byte_value;
         OFF_DST_1:   view.dst_addr[23:16]   = byte_value;
         OFF_DST_2:   view.dst_addr[15:8]    = byte_value;
         OFF_DST_3:   view.dst_addr[7:0]     = byte_value;
         default: ;
      endcase
      pstart = {9'd0, port_start(view.header_words)};
      if (view.header_words >= MIN_HDR_WORDS) begin
         if (off == pstart) begin
            view.src_port[15:8] = byte_value;
         end else if (off == pstart + 16'd1) begin
            view.src_port[7:0] = byte_value;
         end else if (off == pstart + 16'd2) begin
            view.dst_port[15:8] = byte_value;
         end else if (off == pstart + 16'd3) begin
            view.dst_port[7:0] = byte_value;
         end
      end
      if (off != OFFSET_MAX) begin
         view.byte_offset = off + 16'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (proc_valid && advance) begin
         state_in = last_flag ? '0 : view;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/ipv4ft_result.sv */
module ipv4ft_result
   import ipv4ft_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            proc_valid,
   input  logic            last_flag,
   input  frame_state_type view,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [31:0]     rsp_source_address,
   output logic [31:0]     rsp_dest_address,
   output logic [7:0]      rsp_protocol_number,
   output logic [15:0]     rsp_source_port,
   output logic [15:0]     rsp_dest_port,
   output logic [15:0]     rsp_frame_length,
   output logic            rsp_short_frame,
   output logic            rsp_bad_header_length
);

   logic        emit;
   logic        bad_hl;
   logic        ports_used;
   logic        short_fr;
   logic [6:0]  hdr_end;

   logic        valid_ff, valid_in;
   logic [31:0] src_addr_ff, dst_addr_ff;
   logic [7:0]  proto_ff;
   logic [15:0] src_port_ff, dst_port_ff, length_ff;
   logic        short_ff, bad_hl_ff;

   assign emit       = proc_valid && last_flag && (view.ether_kind == IPV4_KIND);
   assign advance    = !(emit && valid_ff && rsp_stall);
   assign bad_hl     = view.header_words < MIN_HDR_WORDS;
   assign ports_used = !bad_hl &&
                       (view.proto_seen == PROTO_TCP || view.proto_seen == PROTO_UDP);
   assign hdr_end    = port_start(view.header_words) + PORT_BYTES;
   assign short_fr   = (view.byte_offset < ADDR_END) ||
                       (ports_used && (view.byte_offset < {9'd0, hdr_end}));

   always_comb begin
      valid_in = valid_ff;
      if (emit && advance) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && advance) begin
         src_addr_ff <= view.src_addr;
         dst_addr_ff <= view.dst_addr;
         proto_ff    <= view.proto_seen;
         src_port_ff <= ports_used ? view.src_port : 16'd0;
         dst_port_ff <= ports_used ? view.dst_port : 16'd0;
         length_ff   <= view.byte_offset;
         short_ff    <= short_fr;
         bad_hl_ff   <= bad_hl;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_source_address    = src_addr_ff;
   assign rsp_dest_address      = dst_addr_ff;
   assign rsp_protocol_number   = proto_ff;
   assign rsp_source_port       = src_port_ff;
   assign rsp_dest_port         = dst_port_ff;
   assign rsp_frame_length      = length_ff;
   assign rsp_short_frame       = short_ff;
   assign rsp_bad_header_length = bad_hl_ff;

   a_hold_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !advance |-> valid_ff && rsp_stall)
      else $error("pipeline held without a blocked result");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit && advance |=> valid_ff)
      else $error("result lost");

   a_bad_hl_no_ports: assert property (@(posedge clock) disable iff (reset)
      valid_ff && bad_hl_ff |-> src_port_ff == 16'd0 && dst_port_ff == 16'd0)
      else $error("ports reported with bad header length");

   a_short_flag: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (length_ff < ADDR_END) |-> short_ff)
      else $error("short frame not flagged");

endmodule

/* tb/tuple_check_pkg.sv */
`timescale 1ns / 1ps
package tuple_check_pkg;
   import ipv4ft_pkg::*;

   typedef struct {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] len;
      logic        short_fr;
      logic        bad_hl;
   } tuple_type;

   localparam int unsigned ETH_LEN     = 14;
   localparam int unsigned WORD_LEN    = 4;
   localparam int unsigned PORTS_LEN   = 4;

   class tuple_tracker;
      tuple_type   expected_tuples[$];
      int unsigned errors;

      logic [15:0] offset;
      logic [15:0] kind;
      logic [3:0]  words;
      logic [7:0]  proto;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         offset = '0;
         kind = '0;
         words = '0;
         proto = '0;
         src_ip = '0;
         dst_ip = '0;
         sport = '0;
         dport = '0;
      endfunction

      // accepted byte transfer: capture, count, and on the last byte predict the tuple
      function void note_byte(logic [7:0] b, logic last);
         int unsigned pstart;
         int unsigned need;
         tuple_type   t;
         bit          used;
         if (offset == OFF_KIND_HI) begin
            kind[15:8] = b;
         end else if (offset == OFF_KIND_LO) begin
            kind[7:0] = b;
         end else if (offset == OFF_IHL) begin
            words = b[3:0];
         end else if (offset == OFF_PROTO) begin
            proto = b;
         end else if (offset >= OFF_SRC_0 && offset <= OFF_SRC_3) begin
            src_ip[8*(OFF_SRC_3 - offset) +: 8] = b;
         end else if (offset >= OFF_DST_0 && offset <= OFF_DST_3) begin
            dst_ip[8*(OFF_DST_3 - offset) +: 8] = b;
         end
         if (words >= MIN_HDR_WORDS) begin
            pstart = ETH_LEN + WORD_LEN * words;
            if (offset == pstart) begin
               sport[15:8] = b;
            end else if (offset == pstart + 1) begin
               sport[7:0] = b;
            end else if (offset == pstart + 2) begin
               dport[15:8] = b;
            end else if (offset == pstart + 3) begin
               dport[7:0] = b;
            end
         end
         if (offset != OFFSET_MAX) begin
            offset = offset + 16'd1;
         end
         if (!last) begin
            return;
         end
         if (kind == IPV4_KIND) begin
            need = ETH_LEN + WORD_LEN * words + PORTS_LEN;
            t.bad_hl = (words < MIN_HDR_WORDS);
            used = !t.bad_hl && (proto == PROTO_TCP || proto == PROTO_UDP);
            t.short_fr = (offset < ADDR_END) || (used && offset < need);
            t.src_ip = src_ip;
            t.dst_ip = dst_ip;
            t.proto = proto;
            t.sport = used ? sport : 16'd0;
            t.dport = used ? dport : 16'd0;
            t.len = offset;
            expected_tuples.insert(expected_tuples.size(), t);
         end
         clear_frame();
      endfunction

      function void check_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
            errors++;
         end
      endfunction

      function void check_tuple(tuple_type got);
         tuple_type exp;
         if (expected_tuples.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none actual src %0h dst %0h",
                     $time, got.src_ip, got.dst_ip);
            errors++;
            return;
         end
         exp = expected_tuples.pop_front();
         check_field("source_address", exp.src_ip, got.src_ip);
         check_field("dest_address", exp.dst_ip, got.dst_ip);
         check_field("protocol_number", exp.proto, got.proto);
         check_field("source_port", exp.sport, got.sport);
         check_field("dest_port", exp.dport, got.dport);
         check_field("frame_length", exp.len, got.len);
         check_field("short_frame", exp.short_fr, got.short_fr);
         check_field("bad_header_length", exp.bad_hl, got.bad_hl);
      endfunction
   endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import ipv4ft_pkg::*;
   import tuple_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_frame_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_dest_address;
   logic [7:0]  rsp_protocol_number;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_dest_port;
   logic [15:0] rsp_frame_length;
   logic        rsp_short_frame;
   logic        rsp_bad_header_length;

   tuple_tracker tracker = new();
   bit           send_idle = 1'b1;
   bit           recv_idle = 1'b1;
   int unsigned  bytes_sent = 0;
   int unsigned  cycles = 0;

   ipv4_five_tuple_extractor_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_frame_byte        (req_frame_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_source_address    (rsp_source_address),
      .rsp_dest_address      (rsp_dest_address),
      .rsp_protocol_number   (rsp_protocol_number),
      .rsp_source_port       (rsp_source_port),
      .rsp_dest_port         (rsp_dest_port),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_short_frame       (rsp_short_frame),
      .rsp_bad_header_length (rsp_bad_header_length)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ipv4_five_tuple_extractor_core] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && recv_idle && ($urandom_range(99) < 36);
   end

   always @(posedge clock) begin
      tuple_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_source_address, rsp_dest_address, rsp_protocol_number,
                 rsp_source_port, rsp_dest_port, rsp_frame_length,
                 rsp_short_frame, rsp_bad_header_length};
         tracker.check_tuple(got);
      end
   end

   // entered and left at a falling edge
   task automatic send_byte(logic [7:0] b, logic last);
      while (send_idle && $urandom_range(99) < 36) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_frame_byte = b;
      req_last_byte = last;
      do @(posedge clock); while (req_stall);
      tracker.note_byte(b, last);
      bytes_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // fill < 0 gives random filler bytes
   task automatic send_frame(int unsigned len, logic [15:0] kind, logic [3:0] words,
                             logic [7:0] proto, int fill);
      logic [7:0] b;
      for (int unsigned i = 0; i < len; i++) begin
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         case (i)
            12: b = kind[15:8];
            13: b = kind[7:0];
            14: b[3:0] = words;
            23: b = proto;
            default: ;
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   initial begin
      int unsigned start_bytes;
      int unsigned frame_idx;
      int unsigned r;
      int unsigned len;
      int unsigned need;
      logic [15:0] kind;
      logic [3:0]  words;
      logic [7:0]  proto;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_frame(42, IPV4_KIND, MIN_HDR_WORDS, PROTO_UDP, 'hFF);
      send_frame(42, IPV4_KIND, MIN_HDR_WORDS, PROTO_TCP, 0);
      send_frame(78, IPV4_KIND, 4'd15, PROTO_TCP, -1);
      send_frame(77, IPV4_KIND, 4'd15, PROTO_UDP, -1);
      send_frame(37, IPV4_KIND, MIN_HDR_WORDS, PROTO_UDP, -1);
      send_frame(60, IPV4_KIND, MIN_HDR_WORDS, 8'd1, -1);
      send_frame(60, IPV4_KIND, 4'd4, PROTO_TCP, -1);
      send_frame(60, IPV4_KIND, 4'd0, PROTO_UDP, -1);
      send_frame(13, IPV4_KIND, MIN_HDR_WORDS, PROTO_TCP, -1);
      send_frame(1, IPV4_KIND, MIN_HDR_WORDS, PROTO_TCP, -1);
      send_frame(20, IPV4_KIND, MIN_HDR_WORDS, PROTO_TCP, -1);
      send_frame(33, IPV4_KIND, MIN_HDR_WORDS, PROTO_UDP, -1);
      send_frame(34, IPV4_KIND, MIN_HDR_WORDS, 8'd1, -1);
      send_frame(60, 16'h86DD, MIN_HDR_WORDS, PROTO_TCP, -1);
      send_frame(60, 16'h0801, MIN_HDR_WORDS, PROTO_UDP, -1);

      start_bytes = bytes_sent;
      frame_idx = 0;
      while (bytes_sent - start_bytes < 920) begin
         send_idle = !(frame_idx >= 6 && frame_idx < 14);
         recv_idle = send_idle;
         if (frame_idx == 3) begin
            while (tracker.expected_tuples.size() != 0) @(negedge clock);
         end
         r = $urandom_range(99);
         if (r < 75) begin
            kind = IPV4_KIND;
            words = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : MIN_HDR_WORDS;
            r = $urandom_range(99);
            proto = (r < 40) ? PROTO_TCP : (r < 80) ? PROTO_UDP : 8'($urandom);
            need = 18 + 4 * words;
            len = ($urandom_range(9) == 0) ? $urandom_range(need, 1)
                                           : need + $urandom_range(30);
         end else begin
            kind = $urandom_range(1) ? 16'($urandom) : IPV4_KIND;
            words = 4'($urandom);
            proto = 8'($urandom);
            len = $urandom_range(90, 1);
         end
         send_frame(len, kind, words, proto, -1);
         frame_idx++;
      end

      send_idle = 1'b1;
      recv_idle = 1'b1;
      while (tracker.expected_tuples.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_tuples.size() == 0) begin
         $display("[ipv4_five_tuple_extractor_core] OK");
      end else begin
         $display("[ipv4_five_tuple_extractor_core] ERROR");
      end
      $finish;
   end

endmodule

/* ipv4_five_tuple_extractor_core.f */
src/ipv4ft_pkg.sv
src/ipv4ft_capture.sv
src/ipv4ft_result.sv
src/ipv4_five_tuple_extractor_core.sv
tb/tuple_check_pkg.sv
tb/testbench.sv
